### sv/spvds_pkg.sv
// Shared types, constants and helper functions for the SPIR-V debug-info stripper.
package spvds_pkg;

    // Default sizes of the stores.
    localparam int DEF_MAX_WORDS = 4096;
    localparam int DEF_MAX_SETS  = 8;
    localparam int DEF_ID_LIMIT  = 4096;
    localparam int HEADER_WORDS  = 5;

    // Module format constants.
    localparam logic [31:0] SPV_MAGIC = 32'h0723_0203;
    localparam int DBG_PREFIX_WORDS = 7;
    localparam int NS_PREFIX_WORDS  = 3;

    // Opcodes that the analysis looks at.
    localparam logic [15:0] OP_NAME        = 16'd5;
    localparam logic [15:0] OP_MEMBER_NAME = 16'd6;
    localparam logic [15:0] OP_STRING      = 16'd7;
    localparam logic [15:0] OP_IMPORT      = 16'd11;
    localparam logic [15:0] OP_EXTINST     = 16'd12;

    // Result status codes.
    localparam logic [2:0] ST_WORD      = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_MAGIC     = 3'd4;
    localparam logic [2:0] ST_LENGTH    = 3'd5;
    localparam logic [2:0] ST_CAPACITY  = 3'd6;

    // One command beat.
    typedef struct packed {
        logic        operation;
        logic [31:0] word;
        logic        last;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [31:0] data_word;
        logic        last_word;
        logic [2:0]  status;
    } t_result;

    // Words of the debug-info set name prefix, first character in the low byte.
    function automatic logic [31:0] dbg_word(input logic [2:0] j);
        logic [31:0] w;
        case (j)
            3'd0:    w = 32'h536E_6F4E;
            3'd1:    w = 32'h6E61_6D65;
            3'd2:    w = 32'h2E63_6974;
            3'd3:    w = 32'h6461_6853;
            3'd4:    w = 32'h442E_7265;
            3'd5:    w = 32'h6775_6265;
            3'd6:    w = 32'h6F66_6E49;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

    // Words of the generic non-semantic prefix.
    function automatic logic [31:0] ns_word(input logic [1:0] j);
        logic [31:0] w;
        case (j)
            2'd0:    w = 32'h536E_6F4E;
            2'd1:    w = 32'h6E61_6D65;
            2'd2:    w = 32'h2E63_6974;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

    // Opcodes that are always dropped: source info, line info and processing notes.
    function automatic logic always_stripped(input logic [15:0] op);
        return op inside {16'd2, 16'd3, 16'd4, 16'd8, 16'd317, 16'd330};
    endfunction

endpackage

### sv/spvds_ram.sv
// Simple dual-port memory with one write port and one registered read port.
module spvds_ram #(
    parameter int W     = 32,
    parameter int DEPTH = spvds_pkg::DEF_MAX_WORDS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/spirv_debug_info_stripper_core.sv
// Top level: word store, analysis sequencer and fetch sequencer of the debug-info stripper.
// A load beat that is not last gives no result. A last load beat runs the check: header
// checks, then three passes (length, import and mark), with each imported set name compared
// in the import pass and the removed-id map cleared before the mark pass. A fetch reads the
// word and then skips stripped instructions, using the store read port and the set-id scan.
// Each result is a one-cycle strobe. Reset is synchronous.
module spirv_debug_info_stripper_core #(
    parameter int MAX_WORDS = spvds_pkg::DEF_MAX_WORDS,
    parameter int MAX_SETS  = spvds_pkg::DEF_MAX_SETS,
    parameter int ID_LIMIT  = spvds_pkg::DEF_ID_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  spvds_pkg::t_cmd    i_cmd,
    output logic               busy,
    output logic               o_valid,
    output spvds_pkg::t_result o_result
);
    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int AW  = $clog2(MAX_WORDS);
    localparam int IDW = $clog2(ID_LIMIT);
    localparam int SCW = $clog2(MAX_SETS + 1);
    localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int LW  = (CW > 16) ? CW : 16;
    localparam int SW  = LW + 1;

    // Sequencer states.
    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_CHK    = 6'd1;
    localparam logic [5:0] S_MAGRD  = 6'd2;
    localparam logic [5:0] S_MAG    = 6'd3;
    localparam logic [5:0] S_LTEST  = 6'd4;
    localparam logic [5:0] S_LRD    = 6'd5;
    localparam logic [5:0] S_LUSE   = 6'd6;
    localparam logic [5:0] S_ITEST  = 6'd7;
    localparam logic [5:0] S_IRD    = 6'd8;
    localparam logic [5:0] S_IHDR   = 6'd9;
    localparam logic [5:0] S_PRD    = 6'd10;
    localparam logic [5:0] S_PUSE   = 6'd11;
    localparam logic [5:0] S_IDRD   = 6'd12;
    localparam logic [5:0] S_IDSET  = 6'd13;
    localparam logic [5:0] S_CLR    = 6'd14;
    localparam logic [5:0] S_MTEST  = 6'd15;
    localparam logic [5:0] S_MRD    = 6'd16;
    localparam logic [5:0] S_MHDR   = 6'd17;
    localparam logic [5:0] S_MIDRD  = 6'd18;
    localparam logic [5:0] S_MID    = 6'd19;
    localparam logic [5:0] S_MSCAN  = 6'd20;
    localparam logic [5:0] S_MXRD   = 6'd21;
    localparam logic [5:0] S_MX     = 6'd22;
    localparam logic [5:0] S_FRD    = 6'd23;
    localparam logic [5:0] S_FWORD  = 6'd24;
    localparam logic [5:0] S_STEST  = 6'd25;
    localparam logic [5:0] S_SRD    = 6'd26;
    localparam logic [5:0] S_SHDR   = 6'd27;
    localparam logic [5:0] S_SIDRD  = 6'd28;
    localparam logic [5:0] S_SID    = 6'd29;
    localparam logic [5:0] S_SMAPRD = 6'd30;
    localparam logic [5:0] S_SMAP   = 6'd31;
    localparam logic [5:0] S_SSCAN  = 6'd32;

    logic [5:0]          r_state, n_state;
    logic [CW-1:0]       r_wc, n_wc;
    logic                r_loading, n_loading;
    logic                r_ovf, n_ovf;
    logic                r_ready, n_ready;
    logic                r_keep, n_keep;
    logic [SCW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_iend, n_iend;
    logic [3:0]          r_off, n_off;
    logic [LW-1:0]       r_len, n_len;
    logic [15:0]         r_op, n_op;
    logic [31:0]         r_val, n_val;
    logic [SCW-1:0]      r_k, n_k;
    logic                r_dbg, n_dbg;
    logic                r_ns, n_ns;
    logic [IDW-1:0]      r_clr, n_clr;
    logic [31:0]         r_oword, n_oword;
    logic                r_ovalid, n_ovalid;
    spvds_pkg::t_result  r_res, n_res;
    logic [31:0]         r_ids [MAX_SETS];

    logic                accept;
    logic [CW-1:0]       wc_base;
    logic [31:0]         mdata;
    logic                map_q;
    logic [15:0]         hlen;
    logic [15:0]         hop;
    logic [CW-1:0]       rem;
    logic                len_bad;
    logic [LW-1:0]       lenc;
    logic [LW-1:0]       addend;
    logic [SW-1:0]       sum;
    logic                st_we;
    logic [AW-1:0]       st_waddr;
    logic                map_we;
    logic [IDW-1:0]      map_waddr;
    logic                map_wdata;
    logic [2:0]          pj;
    logic                dbg_n;
    logic                ns_n;
    logic                p_stop;
    logic                set_hit;
    logic                mid_ok;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Header word fields and the remaining length of the module.
    assign hlen    = mdata[31:16];
    assign hop     = mdata[15:0];
    assign rem     = r_wc - r_ptr;
    assign len_bad = (hlen == 16'd0) || (SW'(hlen) > SW'(rem));
    assign lenc    = len_bad ? LW'(rem) : LW'(hlen);
    assign mid_ok  = (mdata < 32'(ID_LIMIT));

    // Prefix comparison for the word at offset r_off of an import.
    assign pj     = 3'(r_off - 4'd2);
    assign dbg_n  = r_dbg && (mdata == spvds_pkg::dbg_word(pj));
    assign ns_n   = r_ns && ((pj >= 3'(spvds_pkg::NS_PREFIX_WORDS))
                             || (mdata == spvds_pkg::ns_word(pj[1:0])));
    assign p_stop = (pj == 3'(spvds_pkg::DBG_PREFIX_WORDS - 1))
                    || (LW'(r_off) + LW'(1) >= r_len) || (!dbg_n && !ns_n);

    // Set-id scan compare.
    assign set_hit = (r_ids[r_k[SIW-1:0]] == r_val);

    // Shared pointer adder: store addresses and instruction advance.
    always_comb begin
        case (r_state)
            S_LUSE, S_IHDR, S_MHDR: addend = LW'(hlen);
            S_SHDR:                 addend = lenc;
            S_FWORD:                addend = LW'(1);
            S_PUSE, S_IDSET, S_MID, S_MSCAN, S_MX,
            S_SID, S_SMAP, S_SSCAN: addend = r_len;
            default:                addend = LW'(r_off);
        endcase
        sum = SW'(r_ptr) + SW'(addend);
    end

    // Module word store.
    spvds_ram #(
        .W     (32),
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (i_cmd.word),
        .i_raddr (sum[AW-1:0]),
        .o_rdata (mdata)
    );

    // Removed-id map.
    spvds_ram #(
        .W     (1),
        .DEPTH (ID_LIMIT),
        .AW    (IDW)
    ) u_idmap (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (r_val[IDW-1:0]),
        .o_rdata (map_q)
    );

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_wc      = r_wc;
        n_loading = r_loading;
        n_ovf     = r_ovf;
        n_ready   = r_ready;
        n_keep    = r_keep;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_iend    = r_iend;
        n_off     = r_off;
        n_len     = r_len;
        n_op      = r_op;
        n_val     = r_val;
        n_k       = r_k;
        n_dbg     = r_dbg;
        n_ns      = r_ns;
        n_clr     = r_clr;
        n_oword   = r_oword;
        n_ovalid  = 1'b0;
        n_res     = r_res;
        wc_base   = r_loading ? r_wc : '0;
        st_we     = 1'b0;
        st_waddr  = wc_base[AW-1:0];
        map_we    = 1'b0;
        map_waddr = mdata[IDW-1:0];
        map_wdata = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept && !i_cmd.operation) begin
                    // Load beat; the first of a module clears the analysis state.
                    if (!r_loading) begin
                        n_cnt   = '0;
                        n_keep  = 1'b0;
                        n_ptr   = '0;
                        n_iend  = '0;
                        n_ovf   = 1'b0;
                        n_ready = 1'b0;
                    end
                    n_loading = 1'b1;
                    if (wc_base < CW'(MAX_WORDS)) begin
                        st_we = 1'b1;
                        n_wc  = wc_base + CW'(1);
                    end else begin
                        n_wc  = wc_base;
                        n_ovf = 1'b1;
                    end
                    if (i_cmd.last) begin
                        n_loading = 1'b0;
                        n_state   = S_CHK;
                    end
                end else if (accept) begin
                    // Fetch beat.
                    if (!r_ready || (r_ptr >= r_wc)) begin
                        n_ovalid = 1'b1;
                        n_res    = '{32'd0, 1'b0, spvds_pkg::ST_EXHAUSTED};
                    end else begin
                        n_off   = '0;
                        n_state = S_FRD;
                    end
                end
            end

            // Header checks.
            S_CHK: begin
                if (r_ovf) begin
                    n_ovalid = 1'b1;
                    n_res    = '{32'd0, 1'b0, spvds_pkg::ST_CAPACITY};
                    n_state  = S_IDLE;
                end else if (r_wc < CW'(spvds_pkg::HEADER_WORDS)) begin
                    n_ovalid = 1'b1;
                    n_res    = '{32'd0, 1'b0, spvds_pkg::ST_SHORT};
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = '0;
                    n_off   = '0;
                    n_state = S_MAGRD;
                end
            end
            S_MAGRD: n_state = S_MAG;
            S_MAG: begin
                if (mdata != spvds_pkg::SPV_MAGIC) begin
                    n_ovalid = 1'b1;
                    n_res    = '{32'd0, 1'b0, spvds_pkg::ST_MAGIC};
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = CW'(spvds_pkg::HEADER_WORDS);
                    n_state = S_LTEST;
                end
            end

            // Length pass.
            S_LTEST: begin
                if (r_ptr >= r_wc) begin
                    n_ptr   = CW'(spvds_pkg::HEADER_WORDS);
                    n_state = S_ITEST;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_LRD: n_state = S_LUSE;
            S_LUSE: begin
                if (len_bad) begin
                    n_ovalid = 1'b1;
                    n_res    = '{32'd0, 1'b0, spvds_pkg::ST_LENGTH};
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = sum[CW-1:0];
                    n_state = S_LTEST;
                end
            end

            // Import pass: collect debug-info sets and note other non-semantic sets.
            S_ITEST: begin
                if (r_ptr >= r_wc) begin
                    n_clr   = '0;
                    n_state = S_CLR;
                end else begin
                    n_off   = '0;
                    n_state = S_IRD;
                end
            end
            S_IRD: n_state = S_IHDR;
            S_IHDR: begin
                n_len = LW'(hlen);
                n_op  = hop;
                if ((hop == spvds_pkg::OP_IMPORT) && (hlen >= 16'd3)) begin
                    n_off   = 4'd2;
                    n_dbg   = 1'b1;
                    n_ns    = 1'b1;
                    n_state = S_PRD;
                end else begin
                    n_ptr   = sum[CW-1:0];
                    n_state = S_ITEST;
                end
            end
            S_PRD: n_state = S_PUSE;
            S_PUSE: begin
                if (!p_stop) begin
                    n_off   = r_off + 4'd1;
                    n_dbg   = dbg_n;
                    n_ns    = ns_n;
                    n_state = S_PRD;
                end else if (dbg_n && (pj == 3'(spvds_pkg::DBG_PREFIX_WORDS - 1))) begin
                    if (r_cnt >= SCW'(MAX_SETS)) begin
                        n_ovalid = 1'b1;
                        n_res    = '{32'd0, 1'b0, spvds_pkg::ST_CAPACITY};
                        n_state  = S_IDLE;
                    end else begin
                        n_off   = 4'd1;
                        n_state = S_IDRD;
                    end
                end else begin
                    if (ns_n && (pj >= 3'(spvds_pkg::NS_PREFIX_WORDS - 1))) begin
                        n_keep = 1'b1;
                    end
                    n_ptr   = sum[CW-1:0];
                    n_state = S_ITEST;
                end
            end
            S_IDRD: n_state = S_IDSET;
            S_IDSET: begin
                n_cnt   = r_cnt + SCW'(1);
                n_ptr   = sum[CW-1:0];
                n_state = S_ITEST;
            end

            // Clear the removed-id map, one entry a cycle.
            S_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = 1'b0;
                if (r_clr == IDW'(ID_LIMIT - 1)) begin
                    n_ptr   = CW'(spvds_pkg::HEADER_WORDS);
                    n_state = S_MTEST;
                end else begin
                    n_clr = r_clr + IDW'(1);
                end
            end

            // Mark pass: removed result ids.
            S_MTEST: begin
                if (r_ptr >= r_wc) begin
                    n_ready  = 1'b1;
                    n_ptr    = '0;
                    n_iend   = CW'(spvds_pkg::HEADER_WORDS);
                    n_ovalid = 1'b1;
                    n_res    = '{32'd0, 1'b0, spvds_pkg::ST_ACCEPTED};
                    n_state  = S_IDLE;
                end else begin
                    n_off   = '0;
                    n_state = S_MRD;
                end
            end
            S_MRD: n_state = S_MHDR;
            S_MHDR: begin
                n_len = LW'(hlen);
                n_op  = hop;
                if ((hop == spvds_pkg::OP_STRING) && !r_keep && (hlen >= 16'd2)) begin
                    n_off   = 4'd1;
                    n_state = S_MIDRD;
                end else if ((hop == spvds_pkg::OP_IMPORT) && (hlen >= 16'd2)) begin
                    n_off   = 4'd1;
                    n_state = S_MIDRD;
                end else if ((hop == spvds_pkg::OP_EXTINST) && (hlen >= 16'd4)) begin
                    n_off   = 4'd3;
                    n_state = S_MIDRD;
                end else begin
                    n_ptr   = sum[CW-1:0];
                    n_state = S_MTEST;
                end
            end
            S_MIDRD: n_state = S_MID;
            S_MID: begin
                n_val = mdata;
                if (r_op == spvds_pkg::OP_STRING) begin
                    if (!mid_ok) begin
                        n_ovalid = 1'b1;
                        n_res    = '{32'd0, 1'b0, spvds_pkg::ST_CAPACITY};
                        n_state  = S_IDLE;
                    end else begin
                        map_we  = 1'b1;
                        n_ptr   = sum[CW-1:0];
                        n_state = S_MTEST;
                    end
                end else begin
                    n_k     = '0;
                    n_state = S_MSCAN;
                end
            end
            S_MSCAN: begin
                if (r_k >= r_cnt) begin
                    n_ptr   = sum[CW-1:0];
                    n_state = S_MTEST;
                end else if (set_hit) begin
                    if (r_op == spvds_pkg::OP_IMPORT) begin
                        if (r_val >= 32'(ID_LIMIT)) begin
                            n_ovalid = 1'b1;
                            n_res    = '{32'd0, 1'b0, spvds_pkg::ST_CAPACITY};
                            n_state  = S_IDLE;
                        end else begin
                            map_we    = 1'b1;
                            map_waddr = r_val[IDW-1:0];
                            n_ptr     = sum[CW-1:0];
                            n_state   = S_MTEST;
                        end
                    end else begin
                        n_off   = 4'd2;
                        n_state = S_MXRD;
                    end
                end else begin
                    n_k = r_k + SCW'(1);
                end
            end
            S_MXRD: n_state = S_MX;
            S_MX: begin
                if (!mid_ok) begin
                    n_ovalid = 1'b1;
                    n_res    = '{32'd0, 1'b0, spvds_pkg::ST_CAPACITY};
                    n_state  = S_IDLE;
                end else begin
                    map_we  = 1'b1;
                    n_ptr   = sum[CW-1:0];
                    n_state = S_MTEST;
                end
            end

            // Fetch: read the word, then skip stripped instructions.
            S_FRD: n_state = S_FWORD;
            S_FWORD: begin
                n_oword = mdata;
                n_ptr   = sum[CW-1:0];
                n_state = S_STEST;
            end
            S_STEST: begin
                if ((r_ptr < r_wc) && (r_ptr >= CW'(spvds_pkg::HEADER_WORDS))
                    && (r_ptr == r_iend)) begin
                    n_off   = '0;
                    n_state = S_SRD;
                end else begin
                    n_ovalid = 1'b1;
                    n_res    = '{r_oword, (r_ptr >= r_wc), spvds_pkg::ST_WORD};
                    n_state  = S_IDLE;
                end
            end
            S_SRD: n_state = S_SHDR;
            S_SHDR: begin
                n_len = lenc;
                n_op  = hop;
                if (spvds_pkg::always_stripped(hop)
                    || ((hop == spvds_pkg::OP_STRING) && !r_keep)) begin
                    n_ptr   = sum[CW-1:0];
                    n_iend  = sum[CW-1:0];
                    n_state = S_STEST;
                end else if (((hop == spvds_pkg::OP_IMPORT) && (lenc >= LW'(2)))
                             || ((hop inside {spvds_pkg::OP_NAME, spvds_pkg::OP_MEMBER_NAME})
                                 && (lenc >= LW'(2)))) begin
                    n_off   = 4'd1;
                    n_state = S_SIDRD;
                end else if ((hop == spvds_pkg::OP_EXTINST) && (lenc >= LW'(4))) begin
                    n_off   = 4'd3;
                    n_state = S_SIDRD;
                end else begin
                    n_iend   = sum[CW-1:0];
                    n_ovalid = 1'b1;
                    n_res    = '{r_oword, 1'b0, spvds_pkg::ST_WORD};
                    n_state  = S_IDLE;
                end
            end
            S_SIDRD: n_state = S_SID;
            S_SID: begin
                n_val = mdata;
                n_k   = '0;
                if (r_op inside {spvds_pkg::OP_NAME, spvds_pkg::OP_MEMBER_NAME}) begin
                    if (mid_ok) begin
                        n_state = S_SMAPRD;
                    end else begin
                        n_iend   = sum[CW-1:0];
                        n_ovalid = 1'b1;
                        n_res    = '{r_oword, 1'b0, spvds_pkg::ST_WORD};
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_SSCAN;
                end
            end
            S_SMAPRD: n_state = S_SMAP;
            S_SMAP: begin
                if (map_q) begin
                    n_ptr   = sum[CW-1:0];
                    n_iend  = sum[CW-1:0];
                    n_state = S_STEST;
                end else begin
                    n_iend   = sum[CW-1:0];
                    n_ovalid = 1'b1;
                    n_res    = '{r_oword, 1'b0, spvds_pkg::ST_WORD};
                    n_state  = S_IDLE;
                end
            end
            S_SSCAN: begin
                if (r_k >= r_cnt) begin
                    n_iend   = sum[CW-1:0];
                    n_ovalid = 1'b1;
                    n_res    = '{r_oword, 1'b0, spvds_pkg::ST_WORD};
                    n_state  = S_IDLE;
                end else if (set_hit) begin
                    n_ptr   = sum[CW-1:0];
                    n_iend  = sum[CW-1:0];
                    n_state = S_STEST;
                end else begin
                    n_k = r_k + SCW'(1);
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wc      <= '0;
            r_loading <= 1'b0;
            r_ovf     <= 1'b0;
            r_ready   <= 1'b0;
            r_keep    <= 1'b0;
            r_cnt     <= '0;
            r_ptr     <= '0;
            r_iend    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wc      <= n_wc;
            r_loading <= n_loading;
            r_ovf     <= n_ovf;
            r_ready   <= n_ready;
            r_keep    <= n_keep;
            r_cnt     <= n_cnt;
            r_ptr     <= n_ptr;
            r_iend    <= n_iend;
            r_ovalid  <= n_ovalid;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_off   <= n_off;
        r_len   <= n_len;
        r_op    <= n_op;
        r_val   <= n_val;
        r_k     <= n_k;
        r_dbg   <= n_dbg;
        r_ns    <= n_ns;
        r_clr   <= n_clr;
        r_oword <= n_oword;
        r_res   <= n_res;
    end

    // Debug-info set id table.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDSET) begin
            r_ids[r_cnt[SIW-1:0]] <= mdata;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    // A result beat is only shown once the sequencer is back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while the sequencer is busy");

    // Output words come only from an accepted module.
    a_word_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == spvds_pkg::ST_WORD)) |-> r_ready)
        else $error("word beat without an accepted module");

    // The read pointer never passes the end of the stored module.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_wc)
        else $error("pointer beyond the word count");

    // A load beat that is not the last gives no result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cmd.operation && !i_cmd.last) |=> !o_valid)
        else $error("result after a non-final load beat");

endmodule
